/* design/integer_set_store_macros.svh */
// Assertion macros used by the checker file of the integer set store.
`ifndef INTEGER_SET_STORE_MACROS_SVH
`define INTEGER_SET_STORE_MACROS_SVH

// Clocked assertion with an explicit clock and reset.
`define ISS_ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// Clocked assertion on the local clk and rst.
`define ISS_ASSERT(label, prop, msg) \
  `ISS_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

/* design/iss_pkg.sv */
`default_nettype none

package iss_pkg;

  // Default number of entries in the store
  localparam int CAPACITY_DEF = 16;

  // Field widths fixed by the item format
  localparam int VALUE_W = 32;
  localparam int ECNT_W  = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                     opcode;
    logic signed [VALUE_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [ECNT_W-1:0] element_count;
    status_t           status;
    logic              success;
  } res_t;

endpackage

`default_nettype wire

/* design/integer_set_store.sv */
// Integer set store: a set of distinct 32-bit signed values in a packed table.
//
// Requests enter on the s_axis channel: opcode (insert, remove, query, none)
// and a value. One result per request leaves on the m_axis channel: success,
// status (ok, already present, not present, full) and the element count after
// the operation.
//
// A request is looked up by a linear scan of the table, one entry per cycle
// through the single read port of the entry memory and one shared compare.
// A remove that hits moves every entry above the hit down through the same
// read port and the write port. One request is in work at a time;
// s_axis_tready is low until the engine is back in idle, which it enters on
// the same edge on which its result moves to the output register, so a new
// request is not taken before the last result has left the engine.
//
// Results sit in an output register, so the next request may be accepted
// while m_axis_tready is held low; the engine then waits with its finished
// result until the register frees. Reset empties the set and drops any
// pending result; the entry memory needs no clearing.
`default_nettype none

module integer_set_store #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // opcode [1:0], value [33:2], zero [39:34]
  input  wire logic [iss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // success [0], status [2:1], element_count [7:3]
  output logic      [iss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  iss_pkg::req_t req;
  iss_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid;
  iss_pkg::res_t out_data;

  // Unpack the request
  assign req.opcode = iss_pkg::opcode_t'(s_axis_tdata[1:0]);
  assign req.value  = s_axis_tdata[33:2];

  iss_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Take a result when the output register is empty or draining
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

/* design/iss_ram.sv */
`default_nettype none

module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/iss_engine.sv */
`default_nettype none

module iss_engine #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire iss_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output iss_pkg::res_t      res
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [CNT_W-1:0]                count;
  iss_pkg::opcode_t                op;
  logic [iss_pkg::VALUE_W-1:0]     key;
  logic [CNT_W-1:0]                idx;
  logic                            pend;
  logic [AW-1:0]                   pend_idx;
  logic                            res_success;
  iss_pkg::status_t                res_status;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [iss_pkg::VALUE_W-1:0]     ram_wdata;
  logic [iss_pkg::VALUE_W-1:0]     ram_rdata;
  logic                            hit;
  logic                            search_done;
  logic                            has_room;
  logic [CNT_W+iss_pkg::ECNT_W-1:0] count_ext;

  iss_ram #(
    .WIDTH (iss_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared compare: the entry read last cycle against the key
  assign hit         = pend && (ram_rdata == key);
  assign search_done = hit || (!pend && (idx >= count));
  assign has_room    = count < CAP_CNT;

  // Drive the single write port: append on insert, move down on remove
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = key;
    if (state == S_SEARCH && search_done && !hit && op == iss_pkg::OP_INSERT
        && has_room) begin
      ram_we = 1'b1;
    end else if (state == S_SHIFT && pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_idx - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  // Sequence search, shift and result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.opcode;
            key   <= req.value;
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (search_done) begin
            pend        <= 1'b0;
            res_success <= 1'b0;
            res_status  <= iss_pkg::ST_OK;
            state       <= S_FINISH;
            case (op)
              iss_pkg::OP_INSERT: begin
                if (hit) begin
                  res_status <= iss_pkg::ST_PRESENT;
                end else if (!has_room) begin
                  res_status <= iss_pkg::ST_FULL;
                end else begin
                  count       <= count + CNT_W'(1);
                  res_success <= 1'b1;
                end
              end
              iss_pkg::OP_REMOVE: begin
                if (hit) begin
                  idx   <= CNT_W'(pend_idx) + CNT_W'(1);
                  state <= S_SHIFT;
                end else begin
                  res_status <= iss_pkg::ST_ABSENT;
                end
              end
              iss_pkg::OP_QUERY: begin
                if (hit) begin
                  res_success <= 1'b1;
                end else begin
                  res_status <= iss_pkg::ST_ABSENT;
                end
              end
              default: begin
              end
            endcase
          end else if (idx < count) begin
            pend     <= 1'b1;
            pend_idx <= idx[AW-1:0];
            idx      <= idx + CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (idx < count) begin
            pend     <= 1'b1;
            pend_idx <= idx[AW-1:0];
            idx      <= idx + CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count       <= count - CNT_W'(1);
            res_success <= 1'b1;
            res_status  <= iss_pkg::ST_OK;
            state       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = {{iss_pkg::ECNT_W{1'b0}}, count};

  assign req_ready         = (state == S_IDLE);
  assign res_valid         = (state == S_FINISH);
  assign res.success       = res_success;
  assign res.status        = res_status;
  assign res.element_count = count_ext[iss_pkg::ECNT_W-1:0];

endmodule

`default_nettype wire

/* design/iss_checker.sv */
`default_nettype none
`include "integer_set_store_macros.svh"

module iss_checker #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [iss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam logic [4:0] CAP5 = 5'(CAPACITY);
  localparam logic       CAP_SMALL = (CAPACITY < 32);

  // Hold a stalled result
  `ISS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Drop ready while a request is in work
  `ISS_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after a request")

  // Success only with status ok
  `ISS_ASSERT(a_success_ok, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == iss_pkg::ST_OK, "success with error status")

  // Full only at capacity
  `ISS_ASSERT(a_full_count, m_axis_tvalid && m_axis_tdata[2:1] == iss_pkg::ST_FULL |-> m_axis_tdata[7:3] == CAP5, "full below capacity")

  // Count never exceeds capacity, checked when the capacity is below 32
  `ISS_ASSERT(a_count_range, m_axis_tvalid && CAP_SMALL |-> m_axis_tdata[7:3] <= CAP5, "count above capacity")

endmodule

bind integer_set_store iss_checker #(
  .CAPACITY (CAPACITY)
) u_iss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
